// ===== rtl/delta_list_timer_queue_unit_defines.svh =====
// Assertion macros for the delta list timer queue unit.
// Included by files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef DELTA_LIST_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dltq_pkg.sv =====
// Shared types and constants of the delta list timer queue unit.
// No dependencies; used by the controller and the top level.
`timescale 1ns / 1ps

package dltq_pkg;

    // Default sizes.
    localparam int DEF_NUM_CLIENTS = 16;
    localparam int DEF_TIME_BITS   = 32;

    // Most wakeups sent for one tick.
    localparam int WAKE_LIMIT = 16;

    // Result kinds.
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_WAKE  = 1'b1;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_SET  = 3'd0,
        REQ_EXT  = 3'd1,
        REQ_CAN  = 3'd2,
        REQ_GET  = 3'd3,
        REQ_TICK = 3'd4
    } t_req;

    // Controller sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_REM,
        S_REPLY,
        S_UN_C,
        S_UN_P,
        S_UN_N,
        S_INS0,
        S_INS,
        S_INS_C,
        S_INS_P,
        S_INS_T,
        S_TICK,
        S_WAKE_I,
        S_WAKE_N
    } t_state;

    // One result item handed from the controller to the output register.
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [3:0]  client;
        logic [31:0] rem;
        logic        last;
    } t_emit;

    // Status of the list head.
    typedef struct packed {
        logic nonempty;
        logic cd_zero;
    } t_stat;

endpackage

// ===== rtl/delta_list_timer_queue_unit.sv =====
// Delta list timer queue unit: many client timeouts sharing one countdown. Requests set,
// extend or cancel a timeout, ask for the remaining time, or tick. One item is handled at a
// time: a request walks the list one entry per step (an insert walks from the head, a
// remaining-time query walks back to it, an extend does both), and a tick walks the clients
// it wakes. Every list step goes through the one-read, one-write entry memory.
// Uses dltq_pkg, dltq_mem, dltq_ctrl and the assertion macros header.
`timescale 1ns / 1ps
`include "delta_list_timer_queue_unit_defines.svh"

module delta_list_timer_queue_unit #(
    parameter int NUM_CLIENTS = dltq_pkg::DEF_NUM_CLIENTS,
    parameter int TIME_BITS   = dltq_pkg::DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_client_id,
    input  logic [31:0] i_amount,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_reply_kind,
    output logic [3:0]  o_target_client,
    output logic [31:0] o_remaining_ticks,
    output logic        o_last
);

    localparam int SW = $clog2(NUM_CLIENTS);
    localparam int WW = TIME_BITS + 2 * SW;

    dltq_pkg::t_emit emit;
    dltq_pkg::t_stat stat;
    logic            slot_free;
    logic [SW-1:0]   rd_addr, wr_addr;
    logic [WW-1:0]   rd_data, wr_data;
    logic            wr_en;

    logic        r_ovalid;
    logic        r_kind;
    logic [3:0]  r_client;
    logic [31:0] r_rem;
    logic        r_last;

    dltq_mem #(
        .DEPTH (NUM_CLIENTS),
        .AW    (SW),
        .WW    (WW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    dltq_ctrl #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .TIME_BITS   (TIME_BITS),
        .SW          (SW),
        .WW          (WW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_client_id (i_client_id),
        .i_amount    (i_amount),
        .i_slot_free (slot_free),
        .o_emit      (emit),
        .o_stat      (stat),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // The output register can take a new item when empty or being drained.
    assign slot_free = !r_ovalid || i_ready;

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit.valid) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_kind   <= emit.kind;
            r_client <= emit.client;
            r_rem    <= emit.rem;
            r_last   <= emit.last;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_reply_kind      = r_kind;
    assign o_target_client   = r_client;
    assign o_remaining_ticks = r_rem;
    assign o_last            = r_last;

    // Checks on the sequencer and the output register.
    `DLTQ_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accept")
    `DLTQ_ASSERT_IMP(a_empty_cd_zero, !stat.nonempty, stat.cd_zero, "empty list, countdown set")
    `DLTQ_ASSERT_IMP(a_emit_slot_free, emit.valid, slot_free, "item emitted into full register")

endmodule

// ===== rtl/dltq_mem.sv =====
// Entry memory of the delta list: delta, next link and previous link per client.
// One write and one read port, registered read with write-to-read forwarding.
`timescale 1ns / 1ps

module dltq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WW    = 40
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [WW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [WW-1:0] i_wr_data
);

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; a write to the same entry in the same cycle is passed through.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rdata <= i_wr_data;
        end else begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

// ===== rtl/dltq_ctrl.sv =====
// Request sequencer of the delta list timer queue: walks and edits the list in memory.
// Uses dltq_pkg; drives the read and write ports of dltq_mem.
`timescale 1ns / 1ps

module dltq_ctrl #(
    parameter int NUM_CLIENTS = dltq_pkg::DEF_NUM_CLIENTS,
    parameter int TIME_BITS   = dltq_pkg::DEF_TIME_BITS,
    parameter int SW          = $clog2(NUM_CLIENTS),
    parameter int WW          = TIME_BITS + 2 * SW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_req_type,
    input  logic [3:0]        i_client_id,
    input  logic [31:0]       i_amount,
    input  logic              i_slot_free,
    output dltq_pkg::t_emit   o_emit,
    output dltq_pkg::t_stat   o_stat,
    output logic [SW-1:0]     o_rd_addr,
    input  logic [WW-1:0]     i_rd_data,
    output logic              o_wr_en,
    output logic [SW-1:0]     o_wr_addr,
    output logic [WW-1:0]     o_wr_data
);

    localparam int TB = TIME_BITS;
    localparam int CW = $clog2(dltq_pkg::WAKE_LIMIT + 1);
    localparam logic [63:0] TMAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TB);
    localparam logic [63:0] F32MAX = 64'h0000_0000_FFFF_FFFF;

    // Saturating add at the time width.
    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
        logic [TB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TB] ? {TB{1'b1}} : s[TB-1:0];
    endfunction

    dltq_pkg::t_state r_state, n_state;
    dltq_pkg::t_req   r_req, n_req;
    logic [3:0]       r_id, n_id;
    logic             r_ok, n_ok;
    logic [SW-1:0]    r_cid, n_cid;
    logic [TB-1:0]    r_t, n_t;
    logic [TB-1:0]    r_sum, n_sum;
    logic [SW-1:0]    r_ra, n_ra;
    logic [SW-1:0]    r_i, n_i;
    logic [SW-1:0]    r_pv, n_pv;
    logic [SW-1:0]    r_nx, n_nx;
    logic [TB-1:0]    r_dc, n_dc;
    logic             r_hp, n_hp;
    logic             r_hn, n_hn;
    logic [SW-1:0]    r_head, n_head;
    logic             r_ne, n_ne;
    logic [TB-1:0]    r_cd, n_cd;
    logic [NUM_CLIENTS-1:0] r_q, n_q;
    logic [CW-1:0]    r_cnt, n_cnt;

    // Fields of the word at the current read address.
    logic [TB-1:0] wd;
    logic [SW-1:0] wn, wp;
    assign wd = i_rd_data[WW-1 -: TB];
    assign wn = i_rd_data[2*SW-1:SW];
    assign wp = i_rd_data[SW-1:0];

    // Shared decisions.
    logic          q_c, hp_c, hn_c, wake_last, cd_nz;
    logic [63:0]   amt64, sum64;
    logic [TB-1:0] amt_sat;
    logic [TB-1:0] rem_sum;
    dltq_pkg::t_state after_unlink;

    assign q_c       = r_q[r_cid];
    assign hp_c      = (wp != r_cid);
    assign hn_c      = (wn != r_cid);
    assign wake_last = (wd != '0) || (r_cnt == CW'(dltq_pkg::WAKE_LIMIT - 1));
    assign cd_nz     = (r_cd != '0);
    assign amt64     = {32'd0, i_amount};
    assign amt_sat   = (amt64 > TMAX64) ? TMAX64[TB-1:0] : amt64[TB-1:0];
    assign sum64     = 64'(r_sum);
    assign rem_sum   = sat_add(r_sum, wd);
    assign after_unlink = (r_req == dltq_pkg::REQ_CAN) ? dltq_pkg::S_IDLE : dltq_pkg::S_INS0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dltq_pkg::S_IDLE: begin
                if (i_valid) n_state = dltq_pkg::S_DISP;
            end
            dltq_pkg::S_DISP: begin
                unique case (r_req)
                    dltq_pkg::REQ_SET: n_state = !r_ok ? dltq_pkg::S_IDLE :
                                                 (q_c ? dltq_pkg::S_UN_C : dltq_pkg::S_INS0);
                    dltq_pkg::REQ_EXT: n_state = !r_ok ? dltq_pkg::S_IDLE :
                                                 (q_c ? dltq_pkg::S_REM : dltq_pkg::S_INS0);
                    dltq_pkg::REQ_CAN: n_state = (r_ok && q_c) ? dltq_pkg::S_UN_C
                                                               : dltq_pkg::S_IDLE;
                    dltq_pkg::REQ_GET: n_state = (r_ok && q_c) ? dltq_pkg::S_REM
                                                               : dltq_pkg::S_REPLY;
                    dltq_pkg::REQ_TICK: n_state = !r_ne ? dltq_pkg::S_IDLE :
                                                  (cd_nz ? dltq_pkg::S_TICK : dltq_pkg::S_WAKE_I);
                    default: n_state = dltq_pkg::S_IDLE;
                endcase
            end
            dltq_pkg::S_REM: begin
                if (wp == r_ra) begin
                    n_state = (r_req == dltq_pkg::REQ_GET) ? dltq_pkg::S_REPLY
                                                           : dltq_pkg::S_UN_C;
                end
            end
            dltq_pkg::S_REPLY: begin
                if (i_slot_free) n_state = dltq_pkg::S_IDLE;
            end
            dltq_pkg::S_UN_C: begin
                priority if (hp_c) n_state = dltq_pkg::S_UN_P;
                else if (hn_c)     n_state = dltq_pkg::S_UN_N;
                else               n_state = after_unlink;
            end
            dltq_pkg::S_UN_P: n_state = r_hn ? dltq_pkg::S_UN_N : after_unlink;
            dltq_pkg::S_UN_N: n_state = after_unlink;
            dltq_pkg::S_INS0: n_state = r_ne ? dltq_pkg::S_INS : dltq_pkg::S_IDLE;
            dltq_pkg::S_INS: begin
                priority if (r_t < wd) n_state = dltq_pkg::S_INS_C;
                else if (wn == r_ra)   n_state = dltq_pkg::S_INS_T;
                else                   n_state = dltq_pkg::S_INS;
            end
            dltq_pkg::S_INS_C: n_state = (r_pv == r_i) ? dltq_pkg::S_IDLE : dltq_pkg::S_INS_P;
            dltq_pkg::S_INS_P: n_state = dltq_pkg::S_IDLE;
            dltq_pkg::S_INS_T: n_state = dltq_pkg::S_IDLE;
            dltq_pkg::S_TICK:  n_state = cd_nz ? dltq_pkg::S_IDLE : dltq_pkg::S_WAKE_I;
            dltq_pkg::S_WAKE_I: begin
                if (wn == r_ra) begin
                    if (i_slot_free) n_state = dltq_pkg::S_IDLE;
                end else begin
                    n_state = dltq_pkg::S_WAKE_N;
                end
            end
            dltq_pkg::S_WAKE_N: begin
                if (i_slot_free) begin
                    n_state = wake_last ? dltq_pkg::S_IDLE : dltq_pkg::S_WAKE_I;
                end
            end
            default: n_state = dltq_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory writes and result items.
    always_comb begin
        n_req  = r_req;
        n_id   = r_id;
        n_ok   = r_ok;
        n_cid  = r_cid;
        n_t    = r_t;
        n_sum  = r_sum;
        n_ra   = r_ra;
        n_i    = r_i;
        n_pv   = r_pv;
        n_nx   = r_nx;
        n_dc   = r_dc;
        n_hp   = r_hp;
        n_hn   = r_hn;
        n_head = r_head;
        n_ne   = r_ne;
        n_cd   = r_cd;
        n_q    = r_q;
        n_cnt  = r_cnt;
        o_wr_en   = 1'b0;
        o_wr_addr = r_ra;
        o_wr_data = i_rd_data;
        o_emit    = '0;
        unique case (r_state)
            dltq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_req = dltq_pkg::t_req'(i_req_type);
                    n_id  = i_client_id;
                    n_ok  = (int'(i_client_id) < NUM_CLIENTS);
                    n_cid = SW'(i_client_id);
                    n_t   = amt_sat;
                end
            end
            dltq_pkg::S_DISP: begin
                n_ra  = r_cid;
                n_sum = '0;
                n_cnt = '0;
                if ((r_req == dltq_pkg::REQ_TICK) && r_ne) begin
                    n_ra = r_head;
                    if (cd_nz) n_cd = r_cd - 1'b1;
                end
            end
            dltq_pkg::S_REM: begin
                // Sum deltas back to the head.
                n_sum = rem_sum;
                if (wp == r_ra) begin
                    if (r_req != dltq_pkg::REQ_GET) begin
                        n_t  = sat_add(rem_sum, r_t);
                        n_ra = r_cid;
                    end
                end else begin
                    n_ra = wp;
                end
            end
            dltq_pkg::S_REPLY: begin
                if (i_slot_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.kind   = dltq_pkg::KIND_REPLY;
                    o_emit.client = r_id;
                    o_emit.rem    = (sum64 > F32MAX) ? 32'hFFFF_FFFF : sum64[31:0];
                    o_emit.last   = 1'b1;
                end
            end
            dltq_pkg::S_UN_C: begin
                n_pv = wp;
                n_nx = wn;
                n_dc = wd;
                n_hp = hp_c;
                n_hn = hn_c;
                n_q[r_cid] = 1'b0;
                priority if (hp_c) begin
                    n_ra = wp;
                end else if (hn_c) begin
                    n_ra = wn;
                end else begin
                    n_ne = 1'b0;
                    n_cd = '0;
                end
            end
            dltq_pkg::S_UN_P: begin
                // Predecessor skips over the removed entry.
                o_wr_en   = 1'b1;
                o_wr_data = {wd, (r_hn ? r_nx : r_pv), wp};
                if (r_hn) n_ra = r_nx;
            end
            dltq_pkg::S_UN_N: begin
                // Successor absorbs the removed delta.
                o_wr_en   = 1'b1;
                o_wr_data = {sat_add(wd, r_dc), wn, (r_hp ? r_pv : r_ra)};
                if (r_head == r_cid) begin
                    n_head = r_ra;
                    n_cd   = sat_add(wd, r_dc);
                end
            end
            dltq_pkg::S_INS0: begin
                n_q[r_cid] = 1'b1;
                if (!r_ne) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_cid;
                    o_wr_data = {r_t, r_cid, r_cid};
                    n_head    = r_cid;
                    n_ne      = 1'b1;
                    n_cd      = r_t;
                end else begin
                    n_ra = r_head;
                end
            end
            dltq_pkg::S_INS: begin
                // Walk until the new time falls before an entry, or the tail.
                if (r_t < wd) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = {wd - r_t, wn, r_cid};
                    n_pv      = wp;
                    n_i       = r_ra;
                end else begin
                    n_t = r_t - wd;
                    if (wn == r_ra) begin
                        o_wr_en   = 1'b1;
                        o_wr_data = {wd, r_cid, wp};
                        n_pv      = r_ra;
                    end else begin
                        n_ra = wn;
                    end
                end
            end
            dltq_pkg::S_INS_C: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cid;
                o_wr_data = {r_t, r_i, ((r_pv == r_i) ? r_cid : r_pv)};
                if (r_pv == r_i) begin
                    n_head = r_cid;
                    n_cd   = r_t;
                end else begin
                    n_ra = r_pv;
                end
            end
            dltq_pkg::S_INS_P: begin
                o_wr_en   = 1'b1;
                o_wr_data = {wd, r_cid, wp};
            end
            dltq_pkg::S_INS_T: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cid;
                o_wr_data = {r_t, r_cid, r_pv};
            end
            dltq_pkg::S_TICK: begin
                o_wr_en   = 1'b1;
                o_wr_data = {r_cd, wn, wp};
            end
            dltq_pkg::S_WAKE_I: begin
                if (wn == r_ra) begin
                    if (i_slot_free) begin
                        o_emit.valid  = 1'b1;
                        o_emit.kind   = dltq_pkg::KIND_WAKE;
                        o_emit.client = 4'(r_ra);
                        o_emit.last   = 1'b1;
                        n_q[r_ra]     = 1'b0;
                        n_ne          = 1'b0;
                        n_cd          = '0;
                    end
                end else begin
                    n_i  = r_ra;
                    n_ra = wn;
                end
            end
            dltq_pkg::S_WAKE_N: begin
                // Successor becomes the head; the woken entry leaves.
                if (i_slot_free) begin
                    o_wr_en       = 1'b1;
                    o_wr_data     = {wd, wn, r_ra};
                    n_head        = r_ra;
                    n_cd          = wd;
                    n_q[r_i]      = 1'b0;
                    n_cnt         = r_cnt + 1'b1;
                    o_emit.valid  = 1'b1;
                    o_emit.kind   = dltq_pkg::KIND_WAKE;
                    o_emit.client = 4'(r_i);
                    o_emit.last   = wake_last;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dltq_pkg::S_IDLE;
            r_q     <= '0;
            r_head  <= '0;
            r_ne    <= 1'b0;
            r_cd    <= '0;
            r_ra    <= '0;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_head  <= n_head;
            r_ne    <= n_ne;
            r_cd    <= n_cd;
            r_ra    <= n_ra;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_id  <= n_id;
        r_ok  <= n_ok;
        r_cid <= n_cid;
        r_t   <= n_t;
        r_sum <= n_sum;
        r_i   <= n_i;
        r_pv  <= n_pv;
        r_nx  <= n_nx;
        r_dc  <= n_dc;
        r_hp  <= n_hp;
        r_hn  <= n_hn;
        r_cnt <= n_cnt;
    end

    assign o_ready         = (r_state == dltq_pkg::S_IDLE);
    assign o_rd_addr       = n_ra;
    assign o_stat.nonempty = r_ne;
    assign o_stat.cd_zero  = !cd_nz;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the delta list timer queue unit.
// Depends on dltq_pkg and delta_list_timer_queue_unit; keeps its own model of the timer list.
`timescale 1ns / 1ps

module tb;

    localparam int          NCLI      = 16;
    localparam logic [63:0] TICKS_MAX = 64'hFFFF_FFFF;
    localparam logic [2:0]  REQ_FIRST_UNUSED = 3'd5;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          DRAIN_CYCLES = 60;

    typedef struct {
        logic [2:0]  req;
        logic [3:0]  cid;
        logic [31:0] amt;
    } t_request;

    typedef struct {
        logic        kind;
        logic [3:0]  client;
        logic [31:0] rem;
        logic        last;
    } t_notice;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [3:0]  i_client_id = '0;
    logic [31:0] i_amount = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_reply_kind;
    logic [3:0]  o_target_client;
    logic [31:0] o_remaining_ticks;
    logic        o_last;

    delta_list_timer_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_client_id(i_client_id), .i_amount(i_amount),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_reply_kind(o_reply_kind), .o_target_client(o_target_client),
        .o_remaining_ticks(o_remaining_ticks), .o_last(o_last)
    );

    always #2 i_clk = ~i_clk;

    // Model of the delta list.
    logic [63:0] delta_ticks [NCLI];
    int          next_slot   [NCLI];
    int          prev_slot   [NCLI];
    logic        is_queued   [NCLI];
    int          head;
    logic        list_busy;
    logic [63:0] live_count;

    t_request pending_reqs [$];
    t_notice  expected_notices [$];
    int       errors = 0;
    int       cycles = 0;
    int       sent_items = 0;
    int       seen_notices = 0;
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       hold_off_cycles = 0;
    logic     took_item = 1'b0;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > TICKS_MAX) ? TICKS_MAX : s;
    endfunction

    function automatic void list_unlink(int c);
        int  pv;
        int  nx;
        logic has_prev;
        logic has_next;
        pv = prev_slot[c];
        nx = next_slot[c];
        has_prev = (pv != c);
        has_next = (nx != c);
        if (has_prev) next_slot[pv] = has_next ? nx : pv;
        if (has_next) begin
            delta_ticks[nx] = sat_sum(delta_ticks[nx], delta_ticks[c]);
            prev_slot[nx] = has_prev ? pv : nx;
        end
        if (list_busy && head == c) begin
            if (has_next) begin
                head = nx;
                live_count = delta_ticks[nx];
            end else begin
                list_busy = 1'b0;
                live_count = 0;
            end
        end
        is_queued[c] = 1'b0;
    endfunction

    function automatic void list_insert(int c, logic [63:0] t);
        int i;
        int pv;
        is_queued[c] = 1'b1;
        if (!list_busy) begin
            head = c;
            list_busy = 1'b1;
            prev_slot[c] = c;
            next_slot[c] = c;
            delta_ticks[c] = t;
            live_count = t;
            return;
        end
        i = head;
        for (int n = 0; n < NCLI; n++) begin
            if (t < delta_ticks[i]) begin
                pv = prev_slot[i];
                delta_ticks[i] -= t;
                delta_ticks[c] = t;
                if (pv == i) begin
                    head = c;
                    prev_slot[c] = c;
                    live_count = t;
                end else begin
                    next_slot[pv] = c;
                    prev_slot[c] = pv;
                end
                next_slot[c] = i;
                prev_slot[i] = c;
                return;
            end
            t -= delta_ticks[i];
            if (next_slot[i] == i) begin
                next_slot[i] = c;
                prev_slot[c] = i;
                next_slot[c] = c;
                delta_ticks[c] = t;
                return;
            end
            i = next_slot[i];
        end
    endfunction

    // Sum of deltas from the client back to the head.
    function automatic logic [63:0] time_left(int c);
        logic [63:0] sum;
        int i;
        sum = 0;
        i = c;
        for (int n = 0; n < NCLI; n++) begin
            sum = sat_sum(sum, delta_ticks[i]);
            if (prev_slot[i] == i) break;
            i = prev_slot[i];
        end
        return sum;
    endfunction

    // Apply one accepted item to the model and queue the notices it causes.
    function automatic void predict_request(t_request r);
        int c;
        int nx;
        int woken;
        logic [63:0] t;
        t_notice e;
        c = r.cid;
        t = 64'(r.amt);
        case (r.req)
            dltq_pkg::REQ_SET: begin
                if (is_queued[c]) list_unlink(c);
                list_insert(c, t);
            end
            dltq_pkg::REQ_EXT: begin
                if (is_queued[c]) begin
                    t = sat_sum(time_left(c), t);
                    list_unlink(c);
                end
                list_insert(c, t);
            end
            dltq_pkg::REQ_CAN: if (is_queued[c]) list_unlink(c);
            dltq_pkg::REQ_GET: begin
                e.kind = dltq_pkg::KIND_REPLY;
                e.client = r.cid;
                e.rem = is_queued[c] ? 32'(time_left(c)) : '0;
                e.last = 1'b1;
                expected_notices.push_back(e);
            end
            dltq_pkg::REQ_TICK: begin
                if (list_busy) begin
                    if (live_count > 0) begin
                        live_count--;
                        delta_ticks[head] = live_count;
                    end
                    if (live_count == 0) begin
                        // Wake the head and every zero-delta follower, up to WAKE_LIMIT.
                        c = head;
                        delta_ticks[c] = 0;
                        woken = 0;
                        while (woken < dltq_pkg::WAKE_LIMIT) begin
                            nx = next_slot[c];
                            e.kind = dltq_pkg::KIND_WAKE;
                            e.client = c[3:0];
                            e.rem = '0;
                            e.last = 1'b0;
                            expected_notices.push_back(e);
                            woken++;
                            is_queued[c] = 1'b0;
                            if (nx == c) begin
                                list_busy = 1'b0;
                                live_count = 0;
                                break;
                            end
                            head = nx;
                            prev_slot[nx] = nx;
                            live_count = delta_ticks[nx];
                            if (delta_ticks[nx] != 0) break;
                            c = nx;
                        end
                        expected_notices[$].last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
    endtask

    // Random request, mostly short timeouts and ticks so that clients actually expire.
    function automatic t_request random_request();
        t_request r;
        int pick;
        pick = $urandom_range(99);
        r.cid = 4'($urandom_range(NCLI - 1));
        r.amt = $urandom_range(6);
        if ($urandom_range(9) == 0) r.amt = $urandom;
        else if ($urandom_range(19) == 0) r.amt = 32'hFFFF_FFFF - $urandom_range(3);
        if (pick < 28) r.req = dltq_pkg::REQ_SET;
        else if (pick < 38) r.req = dltq_pkg::REQ_EXT;
        else if (pick < 46) r.req = dltq_pkg::REQ_CAN;
        else if (pick < 60) r.req = dltq_pkg::REQ_GET;
        else if (pick < 96) r.req = dltq_pkg::REQ_TICK;
        else r.req = REQ_FIRST_UNUSED + 3'($urandom_range(2));
        return r;
    endfunction

    function automatic void queue_request(logic [2:0] req, int cid, logic [31:0] amt);
        t_request r;
        r.req = req;
        r.cid = cid[3:0];
        r.amt = amt;
        pending_reqs.push_back(r);
    endfunction

    // Driver: offers the next pending item at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took_item)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                t_request r;
                r = pending_reqs.pop_front();
                i_req_type  <= r.req;
                i_client_id <= r.cid;
                i_amount    <= r.amt;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off in the first random phase.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: checks results first, then predicts for a newly accepted item.
    always @(posedge i_clk) begin
        t_request r;
        t_notice e;
        cycles <= cycles + 1;
        took_item <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            seen_notices <= seen_notices + 1;
            if (expected_notices.size() == 0) begin
                errors++;
                $display("unexpected result at cycle %0d for client %0d",
                         cycles, o_target_client);
            end else begin
                e = expected_notices.pop_front();
                if (o_reply_kind !== e.kind) report_mismatch("kind", e.kind, o_reply_kind);
                if (o_target_client !== e.client)
                    report_mismatch("client", e.client, o_target_client);
                if (o_remaining_ticks !== e.rem)
                    report_mismatch("remaining", e.rem, o_remaining_ticks);
                if (o_last !== e.last) report_mismatch("last", e.last, o_last);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            r.req = i_req_type;
            r.cid = i_client_id;
            r.amt = i_amount;
            sent_items <= sent_items + 1;
            predict_request(r);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_all_done();
        while (pending_reqs.size() > 0 || i_valid || expected_notices.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < NCLI; k++) is_queued[k] = 1'b0;
        head = 0;
        list_busy = 1'b0;
        live_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list tick, unused codes, unqueued cancel and query.
        queue_request(dltq_pkg::REQ_TICK, 0, 0);
        for (int k = 0; k < 3; k++) queue_request(REQ_FIRST_UNUSED + 3'(k), k, 32'hFFFF_FFFF);
        queue_request(dltq_pkg::REQ_CAN, 5, 0);
        queue_request(dltq_pkg::REQ_GET, 5, 0);
        // Saturation of an extend on top of the maximum.
        queue_request(dltq_pkg::REQ_SET, 15, 32'hFFFF_FFFF);
        queue_request(dltq_pkg::REQ_EXT, 15, 32'hFFFF_FFFF);
        queue_request(dltq_pkg::REQ_GET, 15, 0);
        queue_request(dltq_pkg::REQ_EXT, 3, 32'h5555_AAAA);
        queue_request(dltq_pkg::REQ_GET, 3, 0);
        queue_request(dltq_pkg::REQ_CAN, 15, 0);
        queue_request(dltq_pkg::REQ_CAN, 3, 0);
        // Equal timeouts keep arrival order; then extend one, query it and tick both out.
        queue_request(dltq_pkg::REQ_SET, 9, 2);
        queue_request(dltq_pkg::REQ_SET, 4, 2);
        queue_request(dltq_pkg::REQ_EXT, 9, 1);
        queue_request(dltq_pkg::REQ_GET, 9, 0);
        queue_request(dltq_pkg::REQ_TICK, 0, 0);
        queue_request(dltq_pkg::REQ_TICK, 0, 0);
        queue_request(dltq_pkg::REQ_TICK, 0, 0);
        wait_all_done();

        // Every client at zero: one tick wakes all sixteen.
        for (int k = NCLI - 1; k >= 0; k--) queue_request(dltq_pkg::REQ_SET, k, 0);
        queue_request(dltq_pkg::REQ_TICK, 0, 0);
        wait_all_done();

        // Random phases with different idling on each side.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = (ph == 1) ? 71 : (ph == 3) ? 20 : 0;
            receiver_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 20 : 0;
            if (ph == 0) hold_off_cycles = 400;
            for (int n = 0; n < 75; n++) pending_reqs.push_back(random_request());
            wait_all_done();
        end

        $display("Drove %0d requests and checked %0d replies and wakeups.",
                 sent_items, seen_notices);
        $display("Covered saturation, full wakeup bursts, idle and stall phases.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== delta_list_timer_queue_unit.f =====
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_mem.sv
rtl/dltq_ctrl.sv
rtl/delta_list_timer_queue_unit.sv
verif/tb.sv
